/* src/mfde_pkg.sv */
// Package for the monochrome framebuffer draw engine.
// It holds the command and pen codes and the control and status structs
// between the controller and the datapath. It depends on nothing.
package mfde_pkg;

	// Command codes.
	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_LINE  = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Pen codes.
	localparam logic [1:0] PEN_ERASE  = 2'd0;
	localparam logic [1:0] PEN_SET    = 2'd1;
	localparam logic [1:0] PEN_INVERT = 2'd2;
	localparam logic [1:0] PEN_NONE   = 2'd3;

	// Byte written by a fill with the set pen.
	localparam logic [7:0] FILL_ONES = 8'hff;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a request and set up the walk
		logic div_step;   // one step of the slope divider
		logic rd_pixel;   // read the byte under the current pixel
		logic wr_pixel;   // write back the pixel byte and advance
		logic sweep_wr;   // write one byte of a clear or fill sweep
		logic sweep_ones; // the sweep writes all ones
		logic rd_byte;    // read the byte addressed by a read request
		logic out_load;   // load the result register
	} mfde_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] command;
		logic [1:0] pen;
		logic       div_last;
		logic       walk_last;
		logic       sweep_last;
		logic       out_free;
	} mfde_stat_t;

endpackage

/* src/mfde_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// It depends on nothing.
module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/mfde_ctrl.sv */
// Controller state machine of the framebuffer draw engine.
// It depends on mfde_pkg for the command codes and the control structs.
module mfde_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_command,
	input  logic [1:0]          in_pen,
	input  mfde_pkg::mfde_stat_t stat,
	output mfde_pkg::mfde_ctrl_t ctrl
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_RD    = 8'b0000_1000,
		ST_WR    = 8'b0001_0000,
		ST_FILL  = 8'b0010_0000,
		ST_RBYTE = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_nxt       = state_q;
		ctrl            = '0;
		ctrl.sweep_ones = (state_q == ST_FILL) && (stat.pen == mfde_pkg::PEN_SET);
		case (state_q)
			ST_CLEAR: begin
				ctrl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					case (in_command)
						mfde_pkg::CMD_FILL: begin
							if (in_pen == mfde_pkg::PEN_SET || in_pen == mfde_pkg::PEN_ERASE) begin
								state_nxt = ST_FILL;
							end else begin
								state_nxt = ST_DONE;
							end
						end
						mfde_pkg::CMD_READ: state_nxt = ST_RBYTE;
						default:            state_nxt = ST_DIV;
					endcase
				end
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				ctrl.rd_pixel = 1'b1;
				state_nxt     = ST_WR;
			end
			ST_WR: begin
				ctrl.wr_pixel = 1'b1;
				state_nxt     = stat.walk_last ? ST_DONE : ST_RD;
			end
			ST_FILL: begin
				ctrl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_RBYTE: begin
				ctrl.rd_byte = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State register; reset starts the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/mfde_dp.sv */
// Datapath of the framebuffer draw engine: request registers, slope divider,
// column walker, store addressing, the framebuffer RAM and the result register.
// It depends on mfde_pkg and mfde_ram.
module mfde_dp #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [47:0]          in_data,
	input  logic [1:0]           in_command,
	output logic [7:0]           out_data,
	output logic [1:0]           out_command,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mfde_pkg::mfde_ctrl_t ctrl,
	output mfde_pkg::mfde_stat_t stat
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);

	// Request fields.
	logic [7:0] xs, ys, xe, ye;
	logic [1:0] pen_in;
	logic [6:0] rc_in;
	logic [2:0] rp_in;
	assign xs     = in_data[7:0];
	assign ys     = in_data[15:8];
	assign xe     = in_data[23:16];
	assign ye     = in_data[31:24];
	assign pen_in = in_data[33:32];
	assign rc_in  = in_data[40:34];
	assign rp_in  = in_data[43:41];

	// Captured request and walker state.
	logic [1:0] cmd_q, pen_q;
	logic [6:0] rc_q;
	logic [2:0] rp_q;
	logic [7:0] x_q;
	logic [8:0] y_q;
	logic [7:0] cnt_q;
	logic [7:0] den_q;
	logic [7:0] r_q;
	logic       neg_q, vert_q;
	logic [8:0] rem_q;
	logic [7:0] quo_q;
	logic [2:0] dcnt_q;
	logic [AW-1:0] sweep_q;
	logic          rok_q;

	// Line setup: order endpoints by x; a point is a one-pixel line.
	logic [7:0] x2, y2, xa, xb, ya, yb, ylo, yhi;
	logic       swap, vert;
	always_comb begin
		x2   = (in_command == mfde_pkg::CMD_POINT) ? xs : xe;
		y2   = (in_command == mfde_pkg::CMD_POINT) ? ys : ye;
		swap = xs > x2;
		xa   = swap ? x2 : xs;
		xb   = swap ? xs : x2;
		ya   = swap ? y2 : ys;
		yb   = swap ? ys : y2;
		ylo  = (ys < y2) ? ys : y2;
		yhi  = (ys < y2) ? y2 : ys;
		vert = (xs == x2) && (ys != y2);
	end

	// Restoring divider step for the magnitude of the slope.
	logic [8:0] trial;
	assign trial = {rem_q[7:0], quo_q[7]} - {1'b0, den_q};

	// Floor quotient and remainder of the signed slope.
	logic [8:0] qd;
	logic [7:0] rd;
	always_comb begin
		if (neg_q && rem_q[7:0] != 8'd0) begin
			qd = ~{1'b0, quo_q} + 9'd1 - 9'd1;
			rd = den_q - rem_q[7:0];
		end else if (neg_q) begin
			qd = ~{1'b0, quo_q} + 9'd1;
			rd = 8'd0;
		end else begin
			qd = {1'b0, quo_q};
			rd = rem_q[7:0];
		end
	end

	// Next column: remainder carry into the row.
	logic [8:0] rsum;
	logic       carry;
	assign rsum  = {1'b0, r_q} + {1'b0, rd};
	assign carry = rsum >= {1'b0, den_q};

	// Pixel addressing and modify.
	logic          on_screen;
	logic [15:0]   pix_full, byte_full;
	logic [AW-1:0] pix_addr, byte_addr;
	logic [7:0]    mask, rdata, new_byte;
	logic          byte_ok;
	assign on_screen = ({1'b0, x_q} < 9'(SCREEN_WIDTH)) && (y_q < 9'(SCREEN_HEIGHT));
	assign pix_full  = 16'(x_q) * 16'(PAGE_COUNT) + 16'(y_q[8:3]);
	assign pix_addr  = pix_full[AW-1:0];
	assign byte_full = 16'(rc_q) * 16'(PAGE_COUNT) + 16'(rp_q);
	assign byte_addr = byte_full[AW-1:0];
	assign byte_ok   = ({2'b0, rc_q} < 9'(SCREEN_WIDTH)) && ({6'b0, rp_q} < 9'(PAGE_COUNT));
	assign mask      = 8'd1 << y_q[2:0];

	always_comb begin
		case (pen_q)
			mfde_pkg::PEN_SET:    new_byte = rdata | mask;
			mfde_pkg::PEN_INVERT: new_byte = rdata ^ mask;
			mfde_pkg::PEN_ERASE:  new_byte = rdata & ~mask;
			default:              new_byte = rdata;
		endcase
	end

	// RAM port selection.
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	assign we    = ctrl.sweep_wr || (ctrl.wr_pixel && on_screen && pen_q != mfde_pkg::PEN_NONE);
	assign waddr = ctrl.sweep_wr ? sweep_q : pix_addr;
	assign wdata = ctrl.sweep_wr ? (ctrl.sweep_ones ? mfde_pkg::FILL_ONES : 8'd0) : new_byte;
	assign re    = ctrl.rd_pixel || ctrl.rd_byte;
	assign raddr = ctrl.rd_byte ? byte_addr : pix_addr;

	mfde_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Request, divider and walker registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= in_command;
			pen_q  <= pen_in;
			rc_q   <= rc_in;
			rp_q   <= rp_in;
			x_q    <= xa;
			y_q    <= vert ? {1'b0, ylo} : {1'b0, ya};
			cnt_q  <= vert ? (yhi - ylo) : (xb - xa);
			den_q  <= xb - xa;
			r_q    <= 8'd0;
			neg_q  <= yb < ya;
			vert_q <= vert;
			rem_q  <= 9'd0;
			quo_q  <= (yb < ya) ? (ya - yb) : (yb - ya);
		end else if (ctrl.div_step) begin
			if (!trial[8]) begin
				rem_q <= trial;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], quo_q[7]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end else if (ctrl.wr_pixel) begin
			cnt_q <= cnt_q - 8'd1;
			if (vert_q) begin
				y_q <= y_q + 9'd1;
			end else begin
				x_q <= x_q + 8'd1;
				y_q <= y_q + qd + {8'd0, carry};
				r_q <= carry ? 8'(rsum - {1'b0, den_q}) : rsum[7:0];
			end
		end
		if (ctrl.rd_byte) begin
			rok_q <= byte_ok;
		end
	end

	// Divider step count and sweep address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q  <= 3'd0;
			sweep_q <= '0;
		end else begin
			if (ctrl.load) begin
				dcnt_q  <= 3'd0;
				sweep_q <= '0;
			end else begin
				if (ctrl.div_step) begin
					dcnt_q <= dcnt_q + 3'd1;
				end
				if (ctrl.sweep_wr) begin
					sweep_q <= sweep_q + 1'b1;
				end
			end
		end
	end

	// Result register.
	logic       ovalid_q;
	logic [7:0] odata_q;
	logic [1:0] ocmd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			odata_q <= (cmd_q == mfde_pkg::CMD_READ && rok_q) ? rdata : 8'd0;
			ocmd_q  <= cmd_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign out_data    = odata_q;
	assign out_command = ocmd_q;

	// Status to the controller.
	assign stat.command    = cmd_q;
	assign stat.pen        = pen_q;
	assign stat.div_last   = (dcnt_q == 3'd7);
	assign stat.walk_last  = (cnt_q == 8'd0);
	assign stat.sweep_last = (sweep_q == AW'(STORE_BYTES - 1));
	assign stat.out_free   = !ovalid_q || out_ready;

endmodule

/* src/mono_framebuffer_draw_engine_core.sv */
// Monochrome framebuffer draw engine: point, line, fill and byte read.
// Point/line: the slope divider runs first, then each pixel is a read-modify-write
// on the single RAM port pair. A fill with the set or erase pen writes every byte
// of the store; a read returns one byte. One request at a time. After reset a
// clearing sweep of SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (1024 by default)
// zeroes the store.
module mono_framebuffer_draw_engine_core #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], pen[33:32],
	// read_column[40:34], read_page[43:41], zero fill [47:44]
	input  logic [47:0] s_tdata,
	// command[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0]
	output logic [7:0]  m_tdata,
	// done_command[1:0]
	output logic [1:0]  m_tuser
);

	mfde_pkg::mfde_ctrl_t ctrl;
	mfde_pkg::mfde_stat_t stat;

	mfde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_command(s_tuser),
		.in_pen    (s_tdata[33:32]),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	mfde_dp #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata),
		.in_command (s_tuser),
		.out_data   (m_tdata),
		.out_command(m_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.ctrl       (ctrl),
		.stat       (stat)
	);

endmodule
